/* hw/rtl/bba_pkg.sv */
// shared constants and types for the buddy block allocator
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
  localparam int POOL_ORDER = 8;
  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ORD_W = 4;
  localparam int ADDR_W = 8;
  localparam int BASE_W = POOL_ORDER + 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic used;
  } blk_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] waddr;
    blk_t wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

/* hw/rtl/bba_table_ram.sv */
// block table memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bba_table_ram
  import bba_pkg::*;
(
  input wire logic clk,
  input wire mem_req_t req,
  output blk_t rdata
);
  blk_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/bba_ctrl.sv */
// sequencer for scan, split, shift and merge over the block table
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl
  import bba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic operation,
  input wire logic [8:0] request_size,
  input wire logic [ADDR_W-1:0] block_address,
  output logic busy,
  output logic done,
  output logic [1:0] status,
  output logic [ADDR_W-1:0] granted_address,
  output mem_req_t req,
  input wire blk_t rdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_INITW, S_SCAN, S_SCANW, S_SPLIT, S_SHUP, S_SHUPW, S_SETSPL,
    S_MCHK, S_MCHKW, S_MERGE, S_SHDN, S_SHDNW, S_SHMV, S_FIN
  } state_t;

  state_t state;
  logic op;
  logic [ORD_W-1:0] want;
  logic [BASE_W-1:0] baddr, base;
  logic [CNT_W-1:0] count, idx, k, bidx;
  blk_t cur;
  logic [1:0] st;
  logic [ORD_W-1:0] o;

  logic [ORD_W-1:0] want_c;
  always_comb begin
    logic [9:0] s;
    s = (request_size == 9'd0) ? 10'd1 : {1'b0, request_size};
    want_c = '0;
    for (int j = 0; j < 10; j++) begin
      if ((10'd1 << j) < s) want_c = ORD_W'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    req.we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_INIT;
      busy <= 1'b1;
      count <= CNT_W'(1);
      req.raddr <= '0;
    end else begin
      case (state)
        S_INIT: begin
          req.we <= 1'b1;
          req.waddr <= '0;
          req.wdata <= '{order: ORD_W'(POOL_ORDER), used: 1'b0};
          state <= S_IDLE;
          busy <= 1'b0;
        end
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            op <= operation;
            want <= want_c;
            baddr <= {1'b0, block_address};
            base <= '0;
            idx <= '0;
            req.raddr <= '0;
            state <= S_INITW;
          end
        end
        S_INITW: begin
          if (op == OP_ALLOC && want > ORD_W'(POOL_ORDER)) begin
            st <= ST_NOFIT;
            state <= S_FIN;
          end else state <= S_SCAN;
        end
        S_SCAN: begin
          cur <= '{order: rdata.order, used: 1'b0};
          if (idx >= count) begin
            st <= (op == OP_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
            state <= S_FIN;
          end else if (op == OP_ALLOC && !rdata.used && rdata.order >= want) begin
            if (count + CNT_W'(rdata.order - want) > CNT_W'(ENTRIES)) begin
              st <= ST_FULL;
              state <= S_FIN;
            end else state <= S_SPLIT;
          end else if (op == OP_FREE && base == baddr) begin
            if (!rdata.used) begin
              st <= ST_NOTFOUND;
              state <= S_FIN;
            end else begin
              state <= S_MCHK;
            end
          end else begin
            base <= base + (BASE_W'(1) << rdata.order);
            idx <= idx + 1'b1;
            req.raddr <= IDX_W'(idx + 1'b1);
            state <= S_SCANW;
          end
        end
        S_SCANW: state <= S_SCAN;
        S_SPLIT: begin
          if (cur.order == want) begin
            req.we <= 1'b1;
            req.waddr <= IDX_W'(idx);
            req.wdata <= '{order: cur.order, used: 1'b1};
            st <= ST_OK;
            state <= S_FIN;
          end else begin
            k <= count;
            req.raddr <= IDX_W'(count - 1'b1);
            state <= S_SHUPW;
          end
        end
        S_SHUPW: state <= S_SHUP;
        S_SHUP: begin
          if (k > idx + 1'b1) begin
            req.we <= 1'b1;
            req.waddr <= IDX_W'(k);
            req.wdata <= rdata;
            k <= k - 1'b1;
            req.raddr <= IDX_W'(k - 2'd2);
            state <= S_SHUPW;
          end else state <= S_SETSPL;
        end
        S_SETSPL: begin
          req.we <= 1'b1;
          req.waddr <= IDX_W'(idx + 1'b1);
          req.wdata <= '{order: cur.order - 1'b1, used: 1'b0};
          cur.order <= cur.order - 1'b1;
          count <= count + 1'b1;
          state <= S_SPLIT;
        end
        S_MCHK: begin
          o <= cur.order;
          if (cur.order >= ORD_W'(POOL_ORDER)) state <= S_MERGE;
          else if (base[cur.order] == 1'b0) begin
            if (idx + 1'b1 >= count) state <= S_MERGE;
            else begin
              bidx <= idx + 1'b1;
              req.raddr <= IDX_W'(idx + 1'b1);
              state <= S_MCHKW;
            end
          end else begin
            if (idx == '0) state <= S_MERGE;
            else begin
              bidx <= idx - 1'b1;
              req.raddr <= IDX_W'(idx - 1'b1);
              state <= S_MCHKW;
            end
          end
        end
        S_MCHKW: state <= S_SHDN;
        S_SHDN: begin
          if (rdata.used || rdata.order != o) state <= S_MERGE;
          else begin
            if (bidx < idx) begin
              idx <= bidx;
              base <= base - (BASE_W'(1) << o);
              k <= idx;
            end else k <= bidx;
            cur.order <= o + 1'b1;
            req.raddr <= IDX_W'((bidx < idx ? idx : bidx) + 1'b1);
            count <= count - 1'b1;
            state <= S_SHDNW;
          end
        end
        S_SHDNW: state <= S_SHMV;
        S_SHMV: begin
          if (k < count) begin
            req.we <= 1'b1;
            req.waddr <= IDX_W'(k);
            req.wdata <= rdata;
            k <= k + 1'b1;
            req.raddr <= IDX_W'(k + 2'd2);
            state <= S_SHDNW;
          end else state <= S_MCHK;
        end
        S_MERGE: begin
          req.we <= 1'b1;
          req.waddr <= IDX_W'(idx);
          req.wdata <= cur;
          st <= ST_OK;
          state <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          status <= st;
          granted_address <= (op == OP_ALLOC && st == ST_OK) ? base[ADDR_W-1:0] : '0;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/buddy_block_allocator_core.sv */
// Buddy block allocator: one request per start, one result word per request.
// The run time of a request grows with the table entries scanned and with the
// entries shifted on each split or merge, over a table of up to 64 entries.
// One request at a time; the table memory read port sets the pace.
// After a synchronous reset, entry 0 is rewritten as one free pool block.
// The receiver cannot stall: done marks the result for one cycle.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_core
  import bba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire logic operation,
  input wire logic [8:0] request_size,
  input wire logic [7:0] block_address,
  output logic done,
  output logic [1:0] status,
  output logic [7:0] granted_address
);
  mem_req_t req;
  blk_t rdata;

  bba_table_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .request_size(request_size), .block_address(block_address),
    .busy(busy), .done(done), .status(status),
    .granted_address(granted_address), .req(req), .rdata(rdata)
  );
endmodule
`default_nettype wire

/* hw/rtl/bba_checker.sv */
// port checker for the buddy block allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bba_port_checker
  import bba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic [1:0] status,
  input wire logic [7:0] granted_address
);
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> granted_address == '0) else $error("address on error");
endmodule

bind buddy_block_allocator_core bba_port_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .granted_address(granted_address)
);
`default_nettype wire

/* tb/bba_checker.sv */
// checker for the buddy block allocator: predicts each result word and compares it
`timescale 1ns / 1ps
`default_nettype none
module bba_checker
  import bba_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic operation,
  input wire logic [8:0] request_size,
  input wire logic [7:0] block_address,
  input wire logic done,
  input wire logic [1:0] status,
  input wire logic [7:0] granted_address,
  output int fail_count,
  output int pending_count
);
  typedef struct packed {
    logic [1:0] st;
    logic [7:0] addr;
  } word_t;

  blk_t pool_table[ENTRIES];
  int table_len;
  word_t expected_words[$];
  int mismatch_count;

  function automatic void pool_reset();
    for (int k = 0; k < ENTRIES; k++) pool_table[k] = '0;
    pool_table[0].order = ORD_W'(POOL_ORDER);
    table_len = 1;
  endfunction

  function automatic word_t pool_alloc(logic [8:0] size);
    word_t w;
    int want, i, base, need;
    w = '0;
    want = 0;
    base = 0;
    while ((1 << want) < ((size == 0) ? 1 : size)) want++;
    if (want > POOL_ORDER) begin
      w.st = ST_NOFIT;
      return w;
    end
    for (i = 0; i < table_len; i++) begin
      if (!pool_table[i].used && pool_table[i].order >= want) break;
      base += 1 << pool_table[i].order;
    end
    if (i >= table_len) begin
      w.st = ST_NOFIT;
      return w;
    end
    need = pool_table[i].order - want;
    if (table_len + need > ENTRIES) begin
      w.st = ST_FULL;
      return w;
    end
    while (pool_table[i].order > want) begin
      for (int k = table_len; k > i + 1; k--) pool_table[k] = pool_table[k-1];
      table_len++;
      pool_table[i].order--;
      pool_table[i+1].order = pool_table[i].order;
      pool_table[i+1].used = 1'b0;
    end
    pool_table[i].used = 1'b1;
    w.st = ST_OK;
    w.addr = base[7:0];
    return w;
  endfunction

  function automatic word_t pool_free(logic [7:0] where);
    word_t w;
    int i, base, o;
    w = '0;
    base = 0;
    for (i = 0; i < table_len; i++) begin
      if (base == where) break;
      base += 1 << pool_table[i].order;
    end
    if (i >= table_len || !pool_table[i].used) begin
      w.st = ST_NOTFOUND;
      return w;
    end
    pool_table[i].used = 1'b0;
    forever begin
      o = pool_table[i].order;
      if (o >= POOL_ORDER) break;
      if ((base & (1 << o)) == 0) begin
        if (i + 1 >= table_len || pool_table[i+1].used || pool_table[i+1].order != o) break;
        for (int k = i + 1; k + 1 < table_len; k++) pool_table[k] = pool_table[k+1];
        table_len--;
        pool_table[i].order = ORD_W'(o + 1);
      end else begin
        if (i == 0 || pool_table[i-1].used || pool_table[i-1].order != o) break;
        for (int k = i; k + 1 < table_len; k++) pool_table[k] = pool_table[k+1];
        table_len--;
        i--;
        pool_table[i].order = ORD_W'(o + 1);
        base -= 1 << o;
      end
    end
    w.st = ST_OK;
    return w;
  endfunction

  assign pending_count = expected_words.size();

  always @(posedge clk) begin
    word_t e;
    if (rst) begin
      pool_reset();
      expected_words.delete();
      fail_count <= 0;
      mismatch_count = 0;
    end else begin
      if (done) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          fail_count <= fail_count + 1;
          if (mismatch_count <= 10)
            $display("unexpected word: status %0d address %0d", status, granted_address);
        end else begin
          e = expected_words.pop_front();
          if (e.st !== status || e.addr !== granted_address) begin
            mismatch_count++;
            fail_count <= fail_count + 1;
            if (mismatch_count <= 10)
              $display("mismatch: expected status %0d address %0d, got %0d %0d",
                       e.st, e.addr, status, granted_address);
          end
        end
      end
      if (start && !busy) begin
        if (operation == OP_ALLOC) expected_words.push_back(pool_alloc(request_size));
        else expected_words.push_back(pool_free(block_address));
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench top: drives allocate and free requests and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import bba_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = OP_ALLOC;
  logic [8:0] request_size = '0;
  logic [7:0] block_address = '0;
  logic busy, done;
  logic [1:0] status;
  logic [7:0] granted_address;
  int fail_count, pending_count;
  int quiet_cycles = 0;
  int idle_pct = 0;
  logic [7:0] held_blocks[$];

  always #6 clk = ~clk;

  buddy_block_allocator_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .request_size(request_size),
    .block_address(block_address), .done(done), .status(status),
    .granted_address(granted_address)
  );

  bba_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .request_size(request_size),
    .block_address(block_address), .done(done), .status(status),
    .granted_address(granted_address), .fail_count(fail_count),
    .pending_count(pending_count)
  );

  // remember granted blocks so random frees mostly hit real ones
  always @(posedge clk) begin
    if (!rst && done && status == ST_OK && granted_address != 8'hff)
      held_blocks.push_back(granted_address);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic op, input logic [8:0] size, input logic [7:0] where);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    request_size <= size;
    block_address <= where;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    int pick, k;
    logic [8:0] size;
    pick = $urandom_range(99);
    if (pick < 45) begin
      case ($urandom_range(3))
        0: size = 9'($urandom_range(256));
        1: size = 9'($urandom_range(511));
        default: size = 9'($urandom_range(8));
      endcase
      send_word(OP_ALLOC, size, 8'($urandom));
    end else if (pick < 88 && held_blocks.size() > 0) begin
      k = $urandom_range(held_blocks.size() - 1);
      send_word(OP_FREE, 9'($urandom), held_blocks[k]);
      held_blocks.delete(k);
    end else begin
      send_word(OP_FREE, 9'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(OP_ALLOC, 9'd0, 8'hff);
    send_word(OP_FREE, 9'h1ff, 8'd0);
    send_word(OP_FREE, 9'd0, 8'd0);
    send_word(OP_ALLOC, 9'd256, 8'd0);
    send_word(OP_ALLOC, 9'd257, 8'd0);
    send_word(OP_ALLOC, 9'h1ff, 8'd0);
    send_word(OP_FREE, 9'd0, 8'd0);
    send_word(OP_FREE, 9'd0, 8'd255);
    send_word(OP_ALLOC, 9'd3, 8'd0);
    send_word(OP_ALLOC, 9'd1, 8'd0);
    send_word(OP_FREE, 9'd0, 8'd5);
    send_word(OP_FREE, 9'd0, 8'd0);
    // drive the table to full with unit blocks
    for (int k = 0; k < 66; k++) send_word(OP_ALLOC, 9'd1, 8'd0);
    send_word(OP_ALLOC, 9'd128, 8'd0);
    for (int k = 0; k < 70; k++) send_word(OP_FREE, 9'd0, 8'(k));
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: idle_pct = 0;
        1: idle_pct = 46;
        2: idle_pct = 0;
        default: idle_pct = 38;
      endcase
      for (int k = 0; k < 450; k++) send_random();
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* buddy_block_allocator_core.f */
hw/rtl/bba_pkg.sv
hw/rtl/bba_table_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator_core.sv
hw/rtl/bba_checker.sv
tb/bba_checker.sv
tb/tb_top.sv
